### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Width of the table size register, and the largest slot count it can name.
  localparam int CFG_W      = 5;
  localparam int SLOT_LIMIT = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 5'd10;

  // The hash keeps 28 bits: the top nibble is folded back in at every byte.
  localparam int HASH_W  = 28;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 4;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_SET = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic [63:0]        key_bytes;
    logic [LEN_W-1:0]   key_len;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_START,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    UNIT_HOLD,
    UNIT_CLEAR,
    UNIT_HASH,
    UNIT_MOD_INIT,
    UNIT_MOD
  } unit_op_t;

  typedef struct packed {
    unit_op_t    op;
    logic [7:0]  data;
  } unit_ctrl_t;

endpackage

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lpht_hash_unit.sv
// ----------------------------------------------------------------------------
// lpht_hash_unit
// Shared shift-xor unit: one key byte per hash step, then one bit per step of
// a restoring remainder to reduce the hash modulo the active slot count.
// ----------------------------------------------------------------------------
module lpht_hash_unit
  import lpht_pkg::*;
(
  input  logic             clk,
  input  unit_ctrl_t       ctrl,
  input  logic [CFG_W-1:0] n_slots,
  output logic [CFG_W-1:0] slot
);

  logic [HASH_W-1:0] h;
  logic [CFG_W-1:0]  r;
  logic [31:0]       sum;
  logic [3:0]        top;
  logic [HASH_W-1:0] h_step;
  logic [CFG_W:0]    r_shift;
  logic [CFG_W:0]    r_sub;

  always_comb begin
    sum     = {h, 4'b0000} + {24'd0, ctrl.data};
    top     = sum[31:28];
    // The top nibble is cleared and folded back in at bits 7:4.
    h_step  = sum[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, top, 4'b0000};
    r_shift = {r, h[HASH_W-1]};
    r_sub   = (r_shift >= {1'b0, n_slots}) ? (r_shift - {1'b0, n_slots}) : r_shift;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      UNIT_CLEAR: begin
        h <= '0;
      end
      UNIT_HASH: begin
        h <= h_step;
      end
      UNIT_MOD_INIT: begin
        r <= '0;
      end
      UNIT_MOD: begin
        r <= r_sub[CFG_W-1:0];
        h <= {h[HASH_W-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign slot = r;

endmodule

### rtl/linear_probing_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probing_hash_table
// Open-addressing key/value table with linear probing, set and get requests.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   cmd, key_bytes, key_len, value
//   rsp       out        rsp_valid/rsp_stall   status, read_value
//   config    in         wr_en                 wr_data (table size)
//
// A request makes one hash step per byte of the clamped key length L and 28
// remainder steps in the shared hash unit, then a read and compare of the
// entry RAM for each of the P slots probed.
// One request is in flight at a time; req_stall is low only when idle.
// Reset marks every slot empty at once; entry contents are not cleared.
// A finished response waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
module linear_probing_hash_table
  import lpht_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             wr_en,
  input  logic [CFG_W-1:0] wr_data
);

  // The size register cannot name more than SLOT_LIMIT slots.
  localparam int DEPTH   = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int KEY_W   = 8 * KEY_BYTES;
  localparam int ENTRY_W = KEY_W + LEN_W + VALUE_W;

  state_t           state, state_next;
  logic [CFG_W-1:0] table_size;
  logic [CFG_W-1:0] n_slots;
  logic [DEPTH-1:0] used;

  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_sh;
  logic [LEN_W-1:0] len_r;
  logic [31:0]      val_r;
  logic [CFG_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic [CFG_W-1:0] probe;
  status_t          res_status;
  logic [31:0]      res_value;

  logic [LEN_W-1:0] len_c;
  logic [KEY_W-1:0] key_m;
  logic             req_acc;

  unit_ctrl_t       unit_ctrl;
  logic [CFG_W-1:0] start_slot;

  logic             ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [LEN_W-1:0] rd_len;
  logic [31:0]      rd_val;
  logic             match;
  logic             slot_free;
  logic             hash_done;
  logic             mod_done;
  logic [CFG_W-1:0] idx_inc;
  logic [IDX_W-1:0] idx_wrap;
  logic [CFG_W-1:0] probe_inc;
  logic             last_probe;
  logic             rsp_free;

  always_comb begin
    if (table_size == '0) begin
      n_slots = CFG_W'(1);
    end else if (table_size > CFG_W'(DEPTH)) begin
      n_slots = CFG_W'(DEPTH);
    end else begin
      n_slots = table_size;
    end
  end

  // Bytes at and above the length take no part in hashing or comparison.
  always_comb begin
    len_c = (req.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.key_len;
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_m[8*b +: 8] = (LEN_W'(b) < len_c) ? req.key_bytes[8*b +: 8] : 8'h00;
    end
  end

  assign rd_key     = ram_rdata[ENTRY_W-1 -: KEY_W];
  assign rd_len     = ram_rdata[VALUE_W +: LEN_W];
  assign rd_val     = ram_rdata[VALUE_W-1:0];
  assign match      = (rd_len == len_r) && (rd_key == key_r);
  assign slot_free  = !used[idx];
  assign hash_done  = (cnt == CFG_W'(len_r));
  assign mod_done   = (cnt == CFG_W'(HASH_W - 1));
  assign idx_inc    = CFG_W'(idx) + CFG_W'(1);
  assign idx_wrap   = (idx_inc == n_slots) ? '0 : idx_inc[IDX_W-1:0];
  assign probe_inc  = probe + CFG_W'(1);
  assign last_probe = (probe_inc == n_slots);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign req_acc    = req_valid && !req_stall;
  assign ram_wdata  = {key_r, len_r, val_r};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = S_PROBE;
      end
      S_PROBE: begin
        state_next = slot_free ? S_DONE : S_CMP;
      end
      S_CMP: begin
        if (match || last_probe) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall      = 1'b1;
    unit_ctrl.op   = UNIT_HOLD;
    unit_ctrl.data = key_sh[7:0];
    ram_we         = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall    = 1'b0;
        unit_ctrl.op = UNIT_CLEAR;
      end
      S_HASH: begin
        unit_ctrl.op = hash_done ? UNIT_MOD_INIT : UNIT_HASH;
      end
      S_MOD: begin
        unit_ctrl.op = UNIT_MOD;
      end
      S_PROBE: begin
        ram_we = slot_free && (cmd_r == CMD_SET);
      end
      S_CMP: begin
        ram_we = match && (cmd_r == CMD_SET);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= TABLE_SIZE_RESET;
      used       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        table_size <= wr_data;
      end
      if (state == S_PROBE && slot_free && cmd_r == CMD_SET) begin
        used[idx] <= 1'b1;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          cmd_r  <= req.cmd;
          key_r  <= key_m;
          key_sh <= key_m;
          len_r  <= len_c;
          val_r  <= req.value;
          cnt    <= '0;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          cnt <= '0;
        end else begin
          cnt    <= cnt + CFG_W'(1);
          key_sh <= key_sh >> 8;
        end
      end
      S_MOD: begin
        cnt <= cnt + CFG_W'(1);
      end
      S_START: begin
        idx   <= start_slot[IDX_W-1:0];
        probe <= '0;
      end
      S_PROBE: begin
        if (slot_free) begin
          res_status <= (cmd_r == CMD_SET) ? ST_INSERTED : ST_MISS;
          res_value  <= '0;
        end
      end
      S_CMP: begin
        if (match) begin
          if (cmd_r == CMD_GET) begin
            res_status <= ST_HIT;
            res_value  <= rd_val;
          end else begin
            res_status <= ST_UPDATED;
            res_value  <= '0;
          end
        end else begin
          probe <= probe_inc;
          idx   <= idx_wrap;
          if (last_probe) begin
            res_status <= (cmd_r == CMD_SET) ? ST_FULL : ST_MISS;
            res_value  <= '0;
          end
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp.status     <= res_status;
          rsp.read_value <= res_value;
        end
      end
      default: begin
      end
    endcase
  end

  lpht_hash_unit u_hash (
    .clk     (clk),
    .ctrl    (unit_ctrl),
    .n_slots (n_slots),
    .slot    (start_slot)
  );

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

endmodule

### bench/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request, response and size-write ports of the hash table,
// keeps its own copy of the slot contents and table size, works out the
// response each accepted request must produce and compares it, field by field,
// with the responses the block returns, oldest first.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             wr_en,
  input  logic [CFG_W-1:0] wr_data,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_W-1:0]   size_reg;
  logic               slot_used [MAX_SLOTS];
  logic [63:0]        slot_key  [MAX_SLOTS];
  logic [LEN_W-1:0]   slot_len  [MAX_SLOTS];
  logic signed [31:0] slot_val  [MAX_SLOTS];
  rsp_t               pending_rsp_q [$];
  rsp_t               want;

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic logic [31:0] pjw_hash(input logic [63:0] key, input int unsigned nbytes);
    logic [31:0] h;
    logic [31:0] top;
    h = '0;
    for (int i = 0; i < nbytes; i++) begin
      h = (h << 4) + 32'(key[8*i +: 8]);
      top = h & 32'hF000_0000;
      if (top != 0) h ^= top >> 24;
      h &= ~top;
    end
    return h;
  endfunction

  // Applies one request to the shadow table and returns the response it earns.
  function automatic rsp_t apply_request(input req_t r);
    int unsigned len;
    int unsigned n;
    int unsigned idx;
    logic [63:0] key;
    logic        is_get;
    logic        done;
    rsp_t        res;
    is_get = (r.cmd == CMD_GET);
    len = (r.key_len > KEY_BYTES) ? KEY_BYTES : 32'(r.key_len);
    // Bytes at and beyond the length play no part; shifting by 64 gives all ones.
    key = r.key_bytes & ((64'd1 << (8 * len)) - 64'd1);
    n = 32'(size_reg);
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    idx = pjw_hash(key, len) % n;
    res.status = is_get ? ST_MISS : ST_FULL;
    res.read_value = '0;
    done = 1'b0;
    for (int p = 0; p < n && !done; p++) begin
      if (!slot_used[idx]) begin
        if (!is_get) begin
          slot_used[idx] = 1'b1;
          slot_key[idx]  = key;
          slot_len[idx]  = LEN_W'(len);
          slot_val[idx]  = r.value;
          res.status     = ST_INSERTED;
        end
        done = 1'b1;
      end else if (slot_len[idx] == len && slot_key[idx] == key) begin
        if (is_get) begin
          res.read_value = slot_val[idx];
          res.status     = ST_HIT;
        end else begin
          slot_val[idx] = r.value;
          res.status    = ST_UPDATED;
        end
        done = 1'b1;
      end else begin
        idx = (idx + 1 == n) ? 0 : idx + 1;
      end
    end
    return res;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] lpht_checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg = TABLE_SIZE_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      pending_rsp_q.delete();
    end else begin
      if (wr_en) size_reg = wr_data;
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          report("response arrived with no request outstanding");
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.read_value !== want.read_value)
            report($sformatf("read_value %0d, expected %0d", rsp.read_value,
                             want.read_value));
        end
      end
      if (req_valid && !req_stall) pending_rsp_q.push_back(apply_request(req));
    end
    outstanding <= pending_rsp_q.size();
  end

endmodule

### bench/linear_probing_hash_table_tb.sv
// ----------------------------------------------------------------------------
// linear_probing_hash_table_tb
// Drives set and get requests into the hash table under a range of table
// sizes, with bursty request traffic and a response side that stalls on its
// own pattern; the checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module linear_probing_hash_table_tb
  import lpht_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1350;
  localparam int N_PHASES  = 9;
  localparam int POOL      = 24;
  localparam int LIMIT     = 1_000_000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             wr_en     = 1'b0;
  logic [CFG_W-1:0] wr_data   = '0;
  int               fail_count;
  int               outstanding;
  int               cycle_count = 0;
  int               burst_left  = 0;

  logic [CFG_W-1:0] phase_size [N_PHASES] = '{16, 3, 31, 0, 17, 1, 7, 16, 12};
  logic [63:0]      pool_key [POOL];
  logic [3:0]       pool_len [POOL];

  always #1 clk = ~clk;

  linear_probing_hash_table #(
    .MAX_SLOTS(16),
    .KEY_BYTES(8)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  lpht_checker #(
    .MAX_SLOTS(16),
    .KEY_BYTES(8)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Offers one request and returns at the edge where it is taken. Requests go
  // out in bursts; a fresh burst may start after a random gap.
  task automatic send(input cmd_t c, input logic [63:0] kb, input logic [3:0] kl,
                      input logic [31:0] v);
    req_t r;
    int   gap;
    r.cmd       = c;
    r.key_bytes = kb;
    r.key_len   = kl;
    r.value     = v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    burst_left--;
  endtask

  task automatic quiesce();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] s);
    quiesce();
    wr_en   <= 1'b1;
    wr_data <= s;
    @(posedge clk);
    wr_en   <= 1'b0;
  endtask

  // Mostly keys from a small pool so that updates and hits are common, with
  // random bytes above the length; the rest is unrelated noise.
  task automatic random_request();
    int          k;
    logic [63:0] kb;
    logic [3:0]  kl;
    if ($urandom_range(0, 99) < 15) begin
      kb = {$urandom, $urandom};
      kl = 4'($urandom_range(0, 15));
      send(cmd_t'($urandom_range(0, 1)), kb, kl, $urandom);
    end else begin
      k  = $urandom_range(0, POOL - 1);
      kb = pool_key[k];
      kl = pool_len[k];
      if (kl == 8 && $urandom_range(0, 2) == 0) kl = 4'($urandom_range(9, 15));
      if (kl < 8 && $urandom_range(0, 1) == 1)
        kb |= {$urandom, $urandom} & ~((64'd1 << (8 * kl)) - 64'd1);
      send(($urandom_range(0, 99) < 45) ? CMD_SET : CMD_GET, kb, kl, $urandom);
    end
  endtask

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[linear_probing_hash_table] ERROR");
    $finish;
  end

  // Response side: runs of differing stall density, and now and then a long
  // hold-off so that the block backs up and stalls its request port.
  initial begin
    int rx_cycles;
    int hold_left;
    int run;
    int mode;
    rx_cycles = 0;
    hold_left = 0;
    run       = 0;
    mode      = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (rx_cycles % 6000 == 3000) begin
        hold_left = 500;
        rsp_stall <= 1'b1;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 3);
          run  = $urandom_range(10, 300);
        end
        run--;
        case (mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= ($urandom_range(0, 1) == 1);
          default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL; i++) begin
      if (i < 18) begin
        pool_len[i] = 4'(i % 9);
        pool_key[i] = {$urandom, $urandom} & ((64'd1 << (8 * pool_len[i])) - 64'd1);
      end else begin
        // Same bytes as an earlier key but one byte longer, the extra byte zero.
        pool_len[i] = pool_len[i - 18] + 4'd1;
        pool_key[i] = pool_key[i - 18];
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset size, starting from an empty table.
    send(CMD_GET, 64'h0, 4'd0, 32'h0);
    send(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h7FFF_FFFF);
    send(CMD_GET, 64'h0, 4'd0, 32'hFFFF_FFFF);
    send(CMD_SET, 64'h1234_5678_9ABC_DEF0, 4'd0, 32'h8000_0000);
    send(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
    send(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
    send(CMD_SET, 64'h0, 4'd8, 32'h0);
    send(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 32'h0);
    send(CMD_SET, 64'h80, 4'd1, 32'h1);
    send(CMD_GET, 64'hFFFF_FFFF_FFFF_FF80, 4'd1, 32'h0);

    // Shrinking a table that holds entries leaves those beyond the new size in place.
    set_size(5'd1);
    send(CMD_SET, 64'h4142, 4'd2, 32'h55);
    send(CMD_GET, 64'h0, 4'd0, 32'h0);
    send(CMD_SET, 64'h80, 4'd1, 32'h5);
    send(CMD_GET, 64'h80, 4'd1, 32'h0);

    set_size(5'd0);
    send(CMD_SET, 64'h1234, 4'd2, 32'hDEAD_BEEF);
    send(CMD_GET, 64'hFF00_1234, 4'd2, 32'h0);

    set_size(5'd31);
    send(CMD_SET, 64'h0102_0304_0506_0708, 4'd9, 32'h1234_5678);
    send(CMD_GET, 64'h0102_0304_0506_0708, 4'd8, 32'h0);
    send(CMD_GET, 64'h0102_0304_0506_0708, 4'd6, 32'h0);

    set_size(5'd17);
    send(CMD_GET, 64'h0, 4'd0, 32'h0);
    send(CMD_SET, 64'h0, 4'd3, 32'h7);
    send(CMD_GET, 64'h0, 4'd3, 32'h0);

    for (int p = 0; p < N_PHASES; p++) begin
      set_size(phase_size[p]);
      repeat (N_RANDOM / N_PHASES) random_request();
    end

    quiesce();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[linear_probing_hash_table] OK");
    end else begin
      $display("[linear_probing_hash_table] ERROR");
    end
    $finish;
  end

endmodule
